@@ design/lkv_pkg.sv @@
// Shared types and constants of the LRU key-value cache.
`default_nettype none

package lkv_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Reported on a get that misses
  localparam logic [DATA_W-1:0] MISS_DATA = '1;
  // Reported on every put
  localparam logic [DATA_W-1:0] PUT_DATA  = '0;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // How the entry unit rewrites rows during the update sweep
  typedef struct packed {
    logic inc_all;    // insert: every valid entry ages by one
    logic new_key;    // target row takes the request key
    logic new_value;  // target row takes the request value
  } lkv_ctl_t;

  // Per-row verdict from the entry unit
  typedef struct packed {
    logic match;  // valid row holding the request key
    logic older;  // valid row older than the oldest seen so far
    logic wr_en;  // row must be written back in the update sweep
  } lkv_flag_t;

endpackage

`default_nettype wire

@@ design/lkv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/lkv_entry_unit.sv @@
// Shared per-row compare and age-update unit of the LRU key-value cache.
`default_nettype none

module lkv_entry_unit #(
  parameter int ENTRIES = 16
) (
  input  wire lkv_pkg::lkv_ctl_t                          ctl,
  input  wire logic [lkv_pkg::KEY_W-1:0]                  req_key,
  input  wire logic [lkv_pkg::DATA_W-1:0]                 req_value,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] tgt_idx,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] thr_age,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] best_age,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] row_idx,
  input  wire logic                                       row_valid,
  input  wire logic [lkv_pkg::KEY_W-1:0]                  row_key,
  input  wire logic [lkv_pkg::DATA_W-1:0]                 row_value,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] row_age,
  output lkv_pkg::lkv_flag_t                              flags,
  output logic      [lkv_pkg::KEY_W-1:0]                  wr_key,
  output logic      [lkv_pkg::DATA_W-1:0]                 wr_value,
  output logic      [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_age
);

  import lkv_pkg::*;

  logic is_tgt;
  logic bump;

  assign is_tgt = (row_idx == tgt_idx);
  // younger than the promoted entry, or everyone on an insert
  assign bump   = ctl.inc_all || (row_age < thr_age);

  always_comb begin
    flags.match = row_valid && (row_key == req_key);
    flags.older = row_valid && (row_age > best_age);
    flags.wr_en = row_valid || is_tgt;
    if (is_tgt) begin
      wr_key   = ctl.new_key   ? req_key   : row_key;
      wr_value = ctl.new_value ? req_value : row_value;
      wr_age   = '0;
    end else begin
      wr_key   = row_key;
      wr_value = row_value;
      wr_age   = bump ? row_age + 1'b1 : row_age;
    end
  end

endmodule

`default_nettype wire

@@ design/lru_key_value_cache.sv @@
// LRU key-value cache: top level, sequencer and entry bookkeeping.
// Usage
//   Request channel (req_valid / req_stall): one transfer carries op, key and
//   value. op = get looks the key up, op = put inserts or updates it.
//   Response channel (rsp_valid / rsp_stall): hit and data per request; data is
//   the stored value on a get hit, all ones on a get miss, zero on a put.
//   Config: cfg_wr_en loads capacity; zero acts as one, above ENTRIES as ENTRIES.
// Timing
//   One request at a time, req_stall high meanwhile. Rows live in one RAM and
//   pass one a cycle through one entry unit: a lookup sweep over every row, a
//   decision state, for anything but a get miss an age-update sweep over every
//   row, and a final state that loads the response register.
// Reset and stall
//   Synchronous reset empties the store (valid bits and occupancy cleared),
//   sets capacity to 16 and drops any pending response. A stalled response
//   holds; the next request is still taken and worked on, and its result
//   waits in the final state until the response register is free.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          op,
  input  wire logic [lkv_pkg::KEY_W-1:0]     key,
  input  wire logic [lkv_pkg::DATA_W-1:0]    value,
  // response
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic                               hit,
  output logic      [lkv_pkg::DATA_W-1:0]    data,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [lkv_pkg::CAP_W-1:0]     cfg_wr_data
);

  import lkv_pkg::*;

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // index / age
  localparam int CW    = $clog2(ENTRIES + 1);                  // count
  localparam int EW    = (CW > CAP_W) ? CW : CAP_W;            // capacity compare
  localparam int ROW_W = KEY_W + DATA_W + IW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;

  // sweep counter and the registered-read pipeline slot behind it
  logic [CW-1:0] cnt;
  logic          p_act;
  logic [IW-1:0] p_idx;

  // captured request
  logic              req_op;
  logic [KEY_W-1:0]  req_key;
  logic [DATA_W-1:0] req_value;

  logic [CAP_W-1:0]   capacity;
  logic [CW-1:0]      occupancy;
  logic [ENTRIES-1:0] entry_valid;

  // lookup sweep results
  logic              match_found;
  logic [IW-1:0]     match_idx;
  logic [IW-1:0]     match_age;
  logic [DATA_W-1:0] match_value;
  logic              free_found;
  logic [IW-1:0]     free_idx;
  logic              oldest_found;
  logic [IW-1:0]     oldest_idx;
  logic [IW-1:0]     oldest_age;

  // update sweep setup
  logic [IW-1:0] tgt_idx;
  logic [IW-1:0] thr_age;
  lkv_ctl_t      ctl;

  // RAM and entry unit
  logic              ram_we;
  logic [IW-1:0]     rd_addr;
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  logic [KEY_W-1:0]  row_key;
  logic [DATA_W-1:0] row_value;
  logic [IW-1:0]     row_age;
  logic              row_valid;
  lkv_flag_t         flags;
  logic [KEY_W-1:0]  wr_key;
  logic [DATA_W-1:0] wr_value;
  logic [IW-1:0]     wr_age;

  logic          sweeping;
  logic          cnt_live;
  logic [EW-1:0] cap_ext;
  logic [EW-1:0] eff_cap;
  logic          full;
  logic          rsp_free;

  assign req_stall = rst || (state != ST_IDLE);

  assign sweeping = (state == ST_SCAN) || (state == ST_UPDATE);
  assign cnt_live = (cnt < CW'(ENTRIES));
  assign rd_addr  = cnt_live ? cnt[IW-1:0] : '0;

  assign row_key   = rd_row[ROW_W-1 -: KEY_W];
  assign row_value = rd_row[IW +: DATA_W];
  assign row_age   = rd_row[IW-1:0];
  assign row_valid = entry_valid[p_idx];

  assign wr_row = {wr_key, wr_value, wr_age};
  assign ram_we = p_act && (state == ST_UPDATE) && flags.wr_en;

  // capacity clipped to 1..ENTRIES
  assign cap_ext = EW'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (EW'(occupancy) >= eff_cap);

  assign rsp_free = !rsp_valid || !rsp_stall;

  lkv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_idx),
    .wdata (wr_row),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  lkv_entry_unit #(
    .ENTRIES (ENTRIES)
  ) u_entry_unit (
    .ctl       (ctl),
    .req_key   (req_key),
    .req_value (req_value),
    .tgt_idx   (tgt_idx),
    .thr_age   (thr_age),
    .best_age  (oldest_age),
    .row_idx   (p_idx),
    .row_valid (row_valid),
    .row_key   (row_key),
    .row_value (row_value),
    .row_age   (row_age),
    .flags     (flags),
    .wr_key    (wr_key),
    .wr_value  (wr_value),
    .wr_age    (wr_age)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // read pipeline slot: row at p_idx arrives from the RAM this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p_act <= 1'b0;
    end else begin
      p_act <= sweeping && cnt_live;
    end
    p_idx <= cnt[IW-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      occupancy   <= '0;
      entry_valid <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // in the final cycle the response register is reloaded below instead
      if (rsp_valid && !rsp_stall && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_op       <= op;
            req_key      <= key;
            req_value    <= value;
            match_found  <= 1'b0;
            free_found   <= 1'b0;
            oldest_found <= 1'b0;
            cnt          <= '0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (p_act) begin
            if (flags.match && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= p_idx;
              match_age   <= row_age;
              match_value <= row_value;
            end
            if (!row_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= p_idx;
            end
            if (row_valid && (!oldest_found || flags.older)) begin
              oldest_found <= 1'b1;
              oldest_idx   <= p_idx;
              oldest_age   <= row_age;
            end
          end
          if (!cnt_live) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (match_found) begin
            // hit: promote, put also rewrites the value
            tgt_idx <= match_idx;
            thr_age <= match_age;
            ctl     <= '{inc_all: 1'b0, new_key: 1'b0, new_value: req_op};
            state   <= ST_UPDATE;
          end else if (req_op == OP_GET) begin
            state <= ST_DONE;
          end else if (full) begin
            // evict the least recent entry and reuse its row
            tgt_idx <= oldest_found ? oldest_idx : '0;
            thr_age <= oldest_age;
            ctl     <= '{inc_all: 1'b0, new_key: 1'b1, new_value: 1'b1};
            state   <= ST_UPDATE;
          end else begin
            // insert into the first free row; everyone else ages
            tgt_idx               <= free_idx;
            thr_age               <= '0;
            ctl                   <= '{inc_all: 1'b1, new_key: 1'b1, new_value: 1'b1};
            entry_valid[free_idx] <= 1'b1;
            occupancy             <= occupancy + 1'b1;
            state                 <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          cnt <= cnt + 1'b1;
          if (!cnt_live) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            hit       <= match_found;
            if (req_op == OP_PUT) begin
              data <= PUT_DATA;
            end else if (match_found) begin
              data <= match_value;
            end else begin
              data <= MISS_DATA;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // occupancy always matches the number of valid rows
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(occupancy))
    else $error("occupancy out of step with valid bits");

  // occupancy never exceeds the store
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(ENTRIES))
    else $error("occupancy beyond store depth");

  // an accepted request starts the lookup sweep from row zero
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == ST_SCAN && cnt == '0)
    else $error("accepted request did not start a sweep");

  // valid bits only change in the decision cycle
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    $past(state) != ST_DECIDE && !$past(rst) |-> $stable(entry_valid))
    else $error("valid bits changed outside the decision cycle");

  // RAM writes happen only in the update sweep
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_UPDATE && p_act)
    else $error("row write outside the update sweep");

endmodule

`default_nettype wire

@@ verif/tb_lru_key_value_cache.sv @@
// Self-checking testbench for the LRU key-value cache: directed table, random traffic, predictor.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
  import lkv_pkg::*;

  // Sizes and limits
  localparam int NENT         = 16;    // entries in the block under test
  localparam int WATCHDOG_CYC = 2000;  // cycles with no transfer on either channel
  localparam int DRAIN_CYC    = 64;    // settle time once every response is in
  localparam int PHASE_ITEMS  = 150;   // random requests per capacity setting
  localparam int N_PHASES     = 7;
  localparam int POOL_MAX     = 24;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } rsp_t;

  // Directed table: a row either writes capacity (held in the value column) or sends a
  // request. Rows with fixed_rsp set carry a hand-written response; the rest take the
  // predictor's answer.
  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    logic              fixed_rsp;
    rsp_t              want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // Recency order after the first ten rows, newest first: 7FFFFFFF, FFFFFFFF, 80000000, 0.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty store after reset: every lookup misses
    '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, MISS_DATA}},
    // inserts at the key and value extremes
    '{ROW_ITEM, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{1'b0, PUT_DATA}},
    '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, PUT_DATA}},
    '{ROW_ITEM, OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, PUT_DATA}},
    '{ROW_ITEM, OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, PUT_DATA}},
    '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF}},
    // value field is ignored on a get
    '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h0000_0000}},
    // put to a present key updates in place
    '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1, '{1'b1, PUT_DATA}},
    '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h1234_5678}},
    '{ROW_ITEM, OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b0, MISS_DATA}},
    // capacity dropped below occupancy: new keys replace the oldest, store stays at four
    '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0002, 1'b0, '0},
    '{ROW_ITEM, OP_PUT, 32'h0000_0005, 32'h5555_5555, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, OP_PUT, 32'h0000_0006, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, '0},
    // capacity zero behaves as one
    '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, OP_PUT, 32'h0000_0007, 32'h0F0F_0F0F, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'h0000_0007, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, '0},
    // capacity above the entry count is clipped, store grows again
    '{ROW_CFG,  OP_GET, 32'h0000_0000, 32'h0000_001F, 1'b0, '0},
    '{ROW_ITEM, OP_PUT, 32'h0000_0008, 32'hF0F0_F0F0, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0}
  };

  // Capacity per random phase: raise to clipped max, cut below occupancy, min, entry count, zero, mid, low
  localparam logic [CAP_W-1:0] PHASE_CAP [N_PHASES] =
    '{5'd31, 5'd5, 5'd1, 5'd16, 5'd0, 5'd9, 5'd3};

  // DUT-facing signals; those the bench drives are known from time zero
  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              req_valid   = 1'b0;
  logic              req_stall;
  logic              op          = OP_GET;
  logic [KEY_W-1:0]  key         = '0;
  logic [DATA_W-1:0] value       = '0;
  logic              rsp_valid;
  logic              rsp_stall   = 1'b0;
  logic              hit;
  logic [DATA_W-1:0] data;
  logic              cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]  cfg_wr_data = '0;

  // Handshake pacing, percent of cycles spent idle
  int send_idle = 33;
  int recv_idle = 49;

  // Predictor state: a private copy of the store and the capacity register
  logic              ent_vld [NENT];
  logic [KEY_W-1:0]  ent_key [NENT];
  logic [DATA_W-1:0] ent_val [NENT];
  int                ent_age [NENT];  // 0 = newest
  int                n_used  = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  // Responses still owed by the block, oldest first
  rsp_t pending_rsp[$];
  rsp_t oldest_rsp;

  // Bookkeeping
  int n_err      = 0;
  int n_sent     = 0;
  int n_cfg      = 0;
  int n_get_hit  = 0;
  int n_get_miss = 0;
  int n_update   = 0;
  int n_insert   = 0;
  int n_evict    = 0;
  int idle_cyc   = 0;

  lru_key_value_cache #(
    .ENTRIES(NENT)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .op         (op),
    .key        (key),
    .value      (value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit        (hit),
    .data       (data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NENT; i++) begin
      ent_vld[i] = 1'b0;
      ent_key[i] = '0;
      ent_val[i] = '0;
      ent_age[i] = 0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Slot s becomes newest; every valid entry that was newer than it ages by one.
  function automatic void make_newest(input int s);
    int a;
    int i;
    a = ent_age[s];
    for (i = 0; i < NENT; i++) begin
      if (ent_vld[i] && i != s && ent_age[i] < a) ent_age[i]++;
    end
    ent_age[s] = 0;
  endfunction

  // One get or put against the private store; returns the response it should produce.
  function automatic rsp_t lru_access(input logic o, input logic [KEY_W-1:0] k,
                                      input logic [DATA_W-1:0] v);
    rsp_t r;
    int   s;
    int   i;
    int   lim;
    s = -1;
    for (i = 0; i < NENT; i++) begin
      if (s < 0 && ent_vld[i] && ent_key[i] == k) s = i;
    end

    if (o == OP_GET) begin
      if (s >= 0) begin
        r.hit  = 1'b1;
        r.data = ent_val[s];
        make_newest(s);
        n_get_hit++;
      end else begin
        r.hit  = 1'b0;
        r.data = MISS_DATA;
        n_get_miss++;
      end
      return r;
    end

    r.data = PUT_DATA;
    r.hit  = (s >= 0);
    if (s >= 0) begin
      ent_val[s] = v;
      make_newest(s);
      n_update++;
      return r;
    end

    // New key: zero acts as one, anything past the entry count as the entry count
    lim = int'(cap_reg);
    if (lim < 1) lim = 1;
    if (lim > NENT) lim = NENT;

    if (n_used >= lim) begin
      // full at this capacity: the oldest slot is reused, occupancy unchanged
      s = -1;
      for (i = 0; i < NENT; i++) begin
        if (ent_vld[i] && (s < 0 || ent_age[i] > ent_age[s])) s = i;
      end
      if (s < 0) s = 0;
      ent_vld[s] = 1'b1;
      ent_key[s] = k;
      ent_val[s] = v;
      make_newest(s);
      n_evict++;
    end else begin
      s = -1;
      for (i = 0; i < NENT; i++) begin
        if (s < 0 && !ent_vld[i]) s = i;
      end
      if (s < 0) s = 0;
      for (i = 0; i < NENT; i++) begin
        if (ent_vld[i]) ent_age[i]++;
      end
      ent_vld[s] = 1'b1;
      ent_key[s] = k;
      ent_val[s] = v;
      ent_age[s] = 0;
      n_used++;
    end
    n_insert++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------------------

  // Offers one request and holds it until the transfer; the expected response is queued
  // at the transfer edge. A fixed response, where given, replaces the predicted one but the
  // predictor still sees the request so its store stays in step.
  task automatic send_req(input logic o, input logic [KEY_W-1:0] k,
                          input logic [DATA_W-1:0] v, input logic fixed, input rsp_t want);
    rsp_t r;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    op        <= o;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (req_stall);
    r = lru_access(o, k, v);
    if (fixed) r = want;
    pending_rsp.push_back(r);
    n_sent++;
  endtask

  // Capacity only changes with the block idle: request channel quiet, nothing owed.
  // Every request yields a response, so an empty queue means the block has finished.
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = c;
    n_cfg++;
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0]  pool [POOL_MAX];
    logic [KEY_W-1:0]  edge_keys [4];
    logic [KEY_W-1:0]  k;
    logic              o;
    int                pool_n;
    int                eff;
    int                pick;
    dir_row_t          row;

    edge_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int i = 0; i < POOL_MAX; i++) pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table, sender 33 % idle, receiver 49 %
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      if (row.kind == ROW_CFG) begin
        write_capacity(row.value[CAP_W-1:0]);
      end else begin
        send_req(row.op, row.key, row.value, row.fixed_rsp, row.want);
      end
    end

    // Random traffic. Keys come mostly from a pool a little larger than the capacity,
    // so hits, updates and evictions all stay frequent; the rest are fully random
    // keys (misses, bit coverage) and the key extremes.
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 2) begin
        send_idle = 33;
        recv_idle = 49;
      end else if (p < 4) begin
        send_idle = 49;
        recv_idle = 33;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_capacity(PHASE_CAP[p]);
      eff = int'(PHASE_CAP[p]);
      if (eff < 1) eff = 1;
      if (eff > NENT) eff = NENT;
      pool_n = eff + 4;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          k = pool[$urandom_range(pool_n - 1)];
        end else if (pick < 93) begin
          k = $urandom;
        end else begin
          k = edge_keys[$urandom_range(3)];
        end
        o = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
        send_req(o, k, $urandom, 1'b0, '0);
      end
    end

    // Drain: every response in, then a quiet spell to catch anything extra
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d requests over %0d capacity settings: %0d get hits, %0d get misses,",
             n_sent, n_cfg, n_get_hit, n_get_miss);
    $display("  %0d updates, %0d inserts of which %0d evicted the oldest entry; %0d mismatches",
             n_update, n_insert, n_evict, n_err);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------------------

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle);
  end

  // Each response transfer is matched against the oldest outstanding expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response transfer: hit %0b data %h", hit, data);
        n_err++;
      end else begin
        oldest_rsp = pending_rsp.pop_front();
        if (hit !== oldest_rsp.hit) begin
          $error("hit: expected %0b, got %0b", oldest_rsp.hit, hit);
          n_err++;
        end
        if (data !== oldest_rsp.data) begin
          $error("data: expected %h, got %h", oldest_rsp.data, data);
          n_err++;
        end
      end
    end
  end

  // Watchdog: too long with no transfer on either channel means the block has hung
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
    if (idle_cyc >= WATCHDOG_CYC) begin
      $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
               idle_cyc, pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
